// ===== hw/rtl/mrc_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte update for the reply checker.
// No dependencies; imported by mrc_frame_core and modbus_rtu_reply_checker.
package mrc_pkg;

  localparam int ByteW   = 8;
  localparam int CrcW    = 16;
  localparam int CfgIdxW = 2;

  localparam logic [CrcW-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CrcW-1:0]  CRC_POLY = 16'hA001;

  localparam logic [ByteW-1:0] SLAVE_ADDR_RST  = 8'h01;
  localparam logic [ByteW-1:0] FUNC_CODE_RST   = 8'h03;
  localparam logic [ByteW-1:0] PAYLOAD_LEN_RST = 8'h02;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLAVE_ADDR  = 2'd0,
    CFG_FUNC_CODE   = 2'd1,
    CFG_PAYLOAD_LEN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FRAME = 2'd1,
    ST_CRC_ERR   = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] slave_addr;
    logic [ByteW-1:0] func_code;
    logic [ByteW-1:0] payload_len;
  } cfg_t;

  typedef struct packed {
    logic [15:0] reading;
    status_e     status;
  } res_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [CrcW-1:0] crc16_feed(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mrc_frame_core.sv =====
// Per-frame state of the reply checker: byte count, running CRC, held bytes,
// header flag and reading. Produces the verdict on the final byte. Uses mrc_pkg.
module mrc_frame_core #(
  parameter int MAX_FRAME = 16,
  parameter int MIN_FRAME = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic [7:0]              rx_byte_i,
  input  logic                    frame_end_i,
  input  mrc_pkg::cfg_t           cfg_i,
  output mrc_pkg::res_t           res_o
);
  import mrc_pkg::*;

  localparam int CntW = $clog2(MAX_FRAME + 1);

  logic [CntW-1:0]  cnt_q, cnt_d, cnt_upd;
  logic [CrcW-1:0]  crc_q, crc_d, crc_upd;
  logic [ByteW-1:0] held0_q, held0_d, held0_upd;
  logic [ByteW-1:0] held1_q, held1_d, held1_upd;
  logic             hdr_q, hdr_d, hdr_upd;
  logic [15:0]      rdg_q, rdg_d, rdg_upd;
  logic             keep;

  always_comb begin
    keep      = cnt_q < CntW'(MAX_FRAME);
    cnt_upd   = cnt_q;
    crc_upd   = crc_q;
    held0_upd = held0_q;
    held1_upd = held1_q;
    hdr_upd   = hdr_q;
    rdg_upd   = rdg_q;

    if (keep) begin
      if (cnt_q == CntW'(0) && rx_byte_i != cfg_i.slave_addr) begin
        hdr_upd = 1'b0;
      end
      if (cnt_q == CntW'(1) && rx_byte_i != cfg_i.func_code) begin
        hdr_upd = 1'b0;
      end
      if (cnt_q == CntW'(2) && rx_byte_i != cfg_i.payload_len) begin
        hdr_upd = 1'b0;
      end
      if (cnt_q == CntW'(3)) begin
        rdg_upd = {rx_byte_i, 8'h00};
      end
      if (cnt_q == CntW'(4)) begin
        rdg_upd = {rdg_q[15:8], rx_byte_i};
      end
      // The byte leaving the hold pair is no longer a CRC candidate.
      if (cnt_q >= CntW'(2)) begin
        crc_upd = crc16_feed(crc_q, held0_q);
      end
      held0_upd = held1_q;
      held1_upd = rx_byte_i;
      cnt_upd   = cnt_q + CntW'(1);
    end

    res_o.reading = '0;
    if (32'(cnt_upd) < 32'(MIN_FRAME) || !hdr_upd) begin
      res_o.status = ST_BAD_FRAME;
    end else if ({held1_upd, held0_upd} == crc_upd) begin
      res_o.status  = ST_OK;
      res_o.reading = rdg_upd;
    end else begin
      res_o.status = ST_CRC_ERR;
    end

    cnt_d   = cnt_q;
    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    hdr_d   = hdr_q;
    rdg_d   = rdg_q;
    if (adv_i) begin
      if (frame_end_i) begin
        // Drop all frame state for the next reply.
        cnt_d   = '0;
        crc_d   = CRC_INIT;
        held0_d = '0;
        held1_d = '0;
        hdr_d   = 1'b1;
        rdg_d   = '0;
      end else begin
        cnt_d   = cnt_upd;
        crc_d   = crc_upd;
        held0_d = held0_upd;
        held1_d = held1_upd;
        hdr_d   = hdr_upd;
        rdg_d   = rdg_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      held0_q <= '0;
      held1_q <= '0;
      hdr_q   <= 1'b1;
      rdg_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      hdr_q   <= hdr_d;
      rdg_q   <= rdg_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_FRAME))
    else $error("byte count passed MAX_FRAME");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && frame_end_i |=> cnt_q == '0 && crc_q == CRC_INIT && hdr_q)
    else $error("frame state not cleared after final byte");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(cnt_q) && $stable(crc_q))
    else $error("frame state moved without an item");

endmodule

// ===== hw/rtl/modbus_rtu_reply_checker.sv =====
// Top level of the Modbus RTU reply checker: config registers, input and result
// registers with stream handshakes. Uses mrc_pkg and mrc_frame_core.
//
//  channel  | dir | handshake            | payload
//  s_axis   | in  | s_tvalid_i/s_tready_o | tdata[7:0] rx_byte, tlast frame_end
//  m_axis   | out | m_tvalid_o/m_tready_i | tdata[1:0] status, [17:2] reading_tenths
//  cfg      | in  | cfg_we_i              | cfg_idx_i register, cfg_data_i value
//
// One item per cycle while no final byte is held by a stalled result; an accepted byte
// passes the input register, then the frame update and CRC byte step into the result register.
// Only the final byte of a frame yields a result item; other bytes produce none.
// Reset clears both registers and restores config to 1/3/2; no clearing pass.
// A stalled result blocks only a further final byte; non-final bytes keep flowing.
module modbus_rtu_reply_checker #(
  parameter int MAX_FRAME = 16,
  parameter int MIN_FRAME = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] rx_byte
  input  logic        s_tlast_i,   // frame_end
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [1:0] status, [17:2] reading_tenths, [23:18] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import mrc_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;
  res_t             core_res;
  logic             out_free, adv;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLAVE_ADDR:  cfg_d.slave_addr  = cfg_data_i;
        CFG_FUNC_CODE:   cfg_d.func_code   = cfg_data_i;
        CFG_PAYLOAD_LEN: cfg_d.payload_len = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // A non-final byte never needs the result slot.
  assign out_free   = !out_valid_q || m_tready_i;
  assign adv        = in_valid_q && (!in_last_q || out_free);
  assign s_tready_o = !in_valid_q || adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_tready_o) begin
      in_valid_d = s_tvalid_i;
    end
    out_valid_d = out_valid_q;
    if (adv && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  mrc_frame_core #(
    .MAX_FRAME (MAX_FRAME),
    .MIN_FRAME (MIN_FRAME)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .rx_byte_i   (in_byte_q),
    .frame_end_i (in_last_q),
    .cfg_i       (cfg_q),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_addr  <= SLAVE_ADDR_RST;
      cfg_q.func_code   <= FUNC_CODE_RST;
      cfg_q.payload_len <= PAYLOAD_LEN_RST;
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_byte_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
    if (adv && in_last_q) begin
      out_res_q <= core_res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'b0, out_res_q.reading, out_res_q.status};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> in_valid_q && in_last_q && out_valid_q)
    else $error("input stalled without a blocked final byte");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && in_last_q))
    else $error("result appeared without a final byte");

  a_reading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.status != ST_OK |-> out_res_q.reading == '0)
    else $error("nonzero reading on a failed frame");

endmodule

// ===== tb/tb_modbus_rtu_reply_checker.sv =====
// Self-checking bench for modbus_rtu_reply_checker: streams reply frames, predicts each
// status and reading in a scoreboard class and compares every result item.
// Depends on mrc_pkg and the modbus_rtu_reply_checker RTL only.
module tb_modbus_rtu_reply_checker;
  import mrc_pkg::*;

  localparam int FrameMax    = 16;
  localparam int FrameMin    = 7;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;
  localparam int ItemsPhase  = 160;
  localparam int NumPhases   = 5;

  // Index 3 of the register port is not a register; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  // Tracks frame state and configuration, holds the replies still to come.
  class reply_scoreboard;
    cfg_t        cfg;
    logic [4:0]  kept_cnt;
    logic [15:0] crc_run;
    logic [7:0]  older_byte;
    logic [7:0]  newer_byte;
    bit          header_ok;
    logic [15:0] reading_acc;
    res_t        replies[$];
    int          errors;
    int          n_bytes;
    int          n_ok;
    int          n_bad;
    int          n_crc;

    function new();
      cfg.slave_addr  = SLAVE_ADDR_RST;
      cfg.func_code   = FUNC_CODE_RST;
      cfg.payload_len = PAYLOAD_LEN_RST;
      clear_frame();
    endfunction

    function void clear_frame();
      kept_cnt    = '0;
      crc_run     = 16'hFFFF;
      older_byte  = '0;
      newer_byte  = '0;
      header_ok   = 1'b1;
      reading_acc = '0;
    endfunction

    static function logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) begin
        r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      end
      return r;
    endfunction

    function void write_cfg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
      case (idx)
        CFG_SLAVE_ADDR:  cfg.slave_addr  = val;
        CFG_FUNC_CODE:   cfg.func_code   = val;
        CFG_PAYLOAD_LEN: cfg.payload_len = val;
        default: ;
      endcase
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      res_t exp;
      n_bytes++;
      if (kept_cnt < FrameMax) begin
        if (kept_cnt == 0 && b != cfg.slave_addr)  header_ok = 1'b0;
        if (kept_cnt == 1 && b != cfg.func_code)   header_ok = 1'b0;
        if (kept_cnt == 2 && b != cfg.payload_len) header_ok = 1'b0;
        if (kept_cnt == 3) reading_acc = {b, 8'h00};
        if (kept_cnt == 4) reading_acc[7:0] = b;
        // The CRC trails two bytes behind so the received CRC never enters it.
        if (kept_cnt >= 2) crc_run = crc_byte(crc_run, older_byte);
        older_byte = newer_byte;
        newer_byte = b;
        kept_cnt++;
      end
      if (!last) return;
      exp.reading = '0;
      if (kept_cnt < FrameMin || !header_ok) begin
        exp.status = ST_BAD_FRAME;
        n_bad++;
      end else if ({newer_byte, older_byte} == crc_run) begin
        exp.status  = ST_OK;
        exp.reading = reading_acc;
        n_ok++;
      end else begin
        exp.status = ST_CRC_ERR;
        n_crc++;
      end
      replies.push_back(exp);
      clear_frame();
    endfunction

    function void check_reply(input logic [23:0] data);
      res_t exp;
      if (replies.size() == 0) begin
        $error("unexpected result item: tdata 0x%06h", data);
        errors++;
        return;
      end
      exp = replies.pop_front();
      if (data[1:0] !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, data[1:0]);
        errors++;
      end
      if (data[17:2] !== exp.reading) begin
        $error("reading_tenths mismatch: expected %0d, actual %0d", exp.reading, data[17:2]);
        errors++;
      end
      if (data[23:18] !== 6'd0) begin
        $error("tdata pad mismatch: expected 0, actual %0d", data[23:18]);
        errors++;
      end
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i;   // [7:0] rx_byte
  logic        s_tlast_i;   // frame_end
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [23:0] m_tdata_o;   // [1:0] status, [17:2] reading_tenths, [23:18] zero
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;

  reply_scoreboard sb;
  bit              quiet;
  int              items_sent;
  int              cycles;

  modbus_rtu_reply_checker #(
    .MAX_FRAME(FrameMax),
    .MIN_FRAME(FrameMin)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tlast_i (s_tlast_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 7);
  endfunction

  function automatic byte_q_t with_crc(input byte_q_t fr);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (fr[i]) c = reply_scoreboard::crc_byte(c, fr[i]);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    return fr;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    logic rdy;
    while (idle_now()) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tlast_i  <= last;
    // Sample ready mid-cycle, where it is settled for the coming edge.
    do begin
      @(negedge clk_i);
      rdy = s_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_byte(b, last);
    items_sent++;
  endtask

  task automatic send_frame(input byte_q_t fr);
    foreach (fr[i]) send_item(fr[i], i == fr.size() - 1);
  endtask

  // Drop valid, let all replies come back, then give the pipeline time to empty.
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] fcode,
                            input logic [7:0] plen);
    logic [7:0] junk;
    junk = $urandom;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SLAVE_ADDR;
    cfg_data_i <= addr;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FUNC_CODE;
    cfg_data_i <= fcode;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PAYLOAD_LEN;
    cfg_data_i <= plen;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IDX_UNUSED;
    cfg_data_i <= junk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_cfg(CFG_SLAVE_ADDR, addr);
    sb.write_cfg(CFG_FUNC_CODE, fcode);
    sb.write_cfg(CFG_PAYLOAD_LEN, plen);
    sb.write_cfg(CFG_IDX_UNUSED, junk);
  endtask

  task automatic send_random_frame();
    byte_q_t fr;
    int      r;
    int      n;
    int      k;
    r = $urandom_range(99);
    // Overlong frames start from a full, valid frame so the kept part can pass.
    n = (r >= 88 && r < 94) ? FrameMax - 5 : $urandom_range(2, FrameMax - 5);
    fr = '{sb.cfg.slave_addr, sb.cfg.func_code, sb.cfg.payload_len};
    repeat (n) fr.push_back(8'($urandom));
    fr = with_crc(fr);
    if (r < 65) begin
    end else if (r < 75) begin
      k = $urandom_range(fr.size() - 1, 3);
      fr[k] = fr[k] ^ (8'h01 << $urandom_range(7));
    end else if (r < 83) begin
      k = $urandom_range(2);
      fr[k] = fr[k] ^ 8'($urandom_range(255, 1));
    end else if (r < 88) begin
      k = $urandom_range(1, FrameMin - 1);
      while (fr.size() > k) void'(fr.pop_back());
    end else if (r < 94) begin
      repeat ($urandom_range(1, 8)) fr.push_back(8'($urandom));
    end else begin
      fr.delete();
      repeat ($urandom_range(1, 20)) fr.push_back(8'($urandom));
    end
    send_frame(fr);
  endtask

  // Result side: check accepted items, stall at random.
  initial begin
    logic        take;
    logic [23:0] data;
    m_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      take = m_tvalid_o && m_tready_i;
      data = m_tdata_o;
      @(posedge clk_i);
      if (take) sb.check_reply(data);
      m_tready_i <= !idle_now();
    end
  end

  initial begin
    byte_q_t fr;
    int      target;
    sb         = new();
    quiet      = 1'b0;
    items_sent = 0;
    rst_ni     <= 1'b0;
    s_tvalid_i <= 1'b0;
    s_tdata_i  <= '0;
    s_tlast_i  <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_SLAVE_ADDR;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames on the reset configuration.
    fr = with_crc('{SLAVE_ADDR_RST, FUNC_CODE_RST, PAYLOAD_LEN_RST, 8'hFF, 8'h00});
    send_frame(fr);
    send_frame('{8'h00});
    fr[0] = ~SLAVE_ADDR_RST;
    send_frame(fr);
    fr = with_crc('{SLAVE_ADDR_RST, FUNC_CODE_RST, PAYLOAD_LEN_RST, 8'h00, 8'hFF});
    fr[6] = ~fr[6];
    send_frame(fr);
    // Short frame with everything else in place: length check must win.
    fr = with_crc('{SLAVE_ADDR_RST, FUNC_CODE_RST, PAYLOAD_LEN_RST, 8'h7F});
    send_frame(fr);
    drain();

    target = items_sent;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: set_config(8'h00, 8'h00, 8'h00);
        2: set_config(8'hFF, 8'hFF, 8'hFF);
        3, 4: set_config(8'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
      quiet  = (ph == 2);
      target = target + ItemsPhase;
      while (items_sent < target) send_random_frame();
      drain();
    end
    quiet = 1'b0;

    $display("Sent %0d bytes in %0d frames over %0d register settings.",
             sb.n_bytes, sb.n_ok + sb.n_bad + sb.n_crc, NumPhases);
    $display("Replies: %0d ok, %0d short or bad header, %0d CRC mismatch.",
             sb.n_ok, sb.n_bad, sb.n_crc);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
